// ===== sv/tsrt_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrt_pkg
// types and codes shared by the time slot reservation table modules
// ----------------------------------------------------------------------------
package tsrt_pkg;

  localparam int unsigned TimeW = 62;
  localparam int unsigned AddrW = 48;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_POLL    = 2'd2,
    OP_ADD     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PAST     = 2'd1,
    ST_CONFLICT = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PA_NONE  = 2'd0,
    PA_START = 2'd1,
    PA_WAIT  = 2'd2
  } poll_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [TimeW-1:0] current_time;
    logic [AddrW-1:0] sender_address;
    logic [AddrW-1:0] receiver_address;
    logic [TimeW-1:0] wanted_start;
    logic [TimeW-1:0] wanted_length;
    logic             device_busy;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [TimeW-1:0] granted_start;
    logic             pair_found;
    logic [1:0]       poll_action;
    logic [TimeW-1:0] wait_delay;
    logic [TimeW-1:0] period_length;
    logic [AddrW-1:0] period_peer;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXPIRE,
    S_SEARCH,
    S_SAT,
    S_CHECK,
    S_SHIFT,
    S_WRITE,
    S_LOOKUP,
    S_POLL,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request, clear scan
    logic scan_clr;   // restart scan index
    logic exp_step;   // one expiry compaction step
    logic exp_fin;    // commit compacted count
    logic srch_step;  // one gap search step
    logic sat;        // saturate idle, set store slot
    logic chk_step;   // one overlap check step
    logic shift_init; // position cursor at end of table
    logic shift_step; // move one entry up
    logic write;      // store new entry
    logic lkp_step;
    logic poll_step;
    logic finish;     // emit result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       scan_end;   // scan index reached count
    logic       stop;       // current step ends the scan early
    logic       conflict;
    logic       full;
    logic       shift_done;
    logic [1:0] op;
    logic       past;
  } sts_t;

endpackage

// ===== sv/tsrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsrt_ctrl
// sequencer stepping one operation through expiry, scan and store phases
// ----------------------------------------------------------------------------
module tsrt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output tsrt_pkg::cmd_t  cmd,
  input  tsrt_pkg::sts_t  sts
);

  tsrt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsrt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tsrt_pkg::S_IDLE: begin
        if (start) state_next = tsrt_pkg::S_EXPIRE;
      end
      tsrt_pkg::S_EXPIRE: begin
        if (sts.scan_end) begin
          unique case (sts.op)
            tsrt_pkg::OP_RESERVE: state_next = sts.past ? tsrt_pkg::S_DONE : tsrt_pkg::S_SEARCH;
            tsrt_pkg::OP_LOOKUP:  state_next = tsrt_pkg::S_LOOKUP;
            tsrt_pkg::OP_POLL:    state_next = tsrt_pkg::S_POLL;
            default:              state_next = tsrt_pkg::S_SAT;
          endcase
        end
      end
      tsrt_pkg::S_SEARCH: begin
        if (sts.scan_end || sts.stop) state_next = tsrt_pkg::S_SAT;
      end
      tsrt_pkg::S_SAT: state_next = tsrt_pkg::S_CHECK;
      tsrt_pkg::S_CHECK: begin
        if (sts.conflict) state_next = tsrt_pkg::S_DONE;
        else if (sts.scan_end) state_next = sts.full ? tsrt_pkg::S_DONE : tsrt_pkg::S_SHIFT;
      end
      tsrt_pkg::S_SHIFT: begin
        if (sts.shift_done) state_next = tsrt_pkg::S_WRITE;
      end
      tsrt_pkg::S_WRITE: state_next = tsrt_pkg::S_DONE;
      tsrt_pkg::S_LOOKUP: begin
        if (sts.scan_end) state_next = tsrt_pkg::S_DONE;
      end
      tsrt_pkg::S_POLL: begin
        if (sts.scan_end || sts.stop) state_next = tsrt_pkg::S_DONE;
      end
      tsrt_pkg::S_DONE: state_next = tsrt_pkg::S_IDLE;
      default: state_next = tsrt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != tsrt_pkg::S_IDLE);
    unique case (state)
      tsrt_pkg::S_IDLE:   cmd.load = start;
      tsrt_pkg::S_EXPIRE: begin
        cmd.exp_step = ~sts.scan_end;
        cmd.exp_fin  = sts.scan_end;
      end
      tsrt_pkg::S_SEARCH: cmd.srch_step = ~sts.scan_end & ~sts.stop;
      tsrt_pkg::S_SAT: begin
        cmd.sat = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      tsrt_pkg::S_CHECK: begin
        cmd.chk_step = ~sts.scan_end;
        cmd.shift_init = sts.scan_end;
        cmd.finish = sts.conflict | (sts.scan_end & sts.full);
      end
      tsrt_pkg::S_SHIFT:  cmd.shift_step = ~sts.shift_done;
      tsrt_pkg::S_WRITE:  begin
        cmd.write = 1'b1;
        cmd.finish = 1'b1;
      end
      tsrt_pkg::S_LOOKUP: begin
        cmd.lkp_step = ~sts.scan_end;
        cmd.finish = sts.scan_end;
      end
      tsrt_pkg::S_POLL: begin
        cmd.poll_step = ~sts.scan_end;
        cmd.finish = sts.scan_end | sts.stop;
      end
      tsrt_pkg::S_DONE: cmd.finish = sts.past & (sts.op == tsrt_pkg::OP_RESERVE);
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/tsrt_datapath.sv =====
// ----------------------------------------------------------------------------
// tsrt_datapath
// entry store, scan index and the comparators of each phase
// ----------------------------------------------------------------------------
module tsrt_datapath #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tsrt_pkg::req_t                req,
  input  logic [tsrt_pkg::AddrW-1:0]    own_addr,
  input  tsrt_pkg::cmd_t                cmd,
  output tsrt_pkg::sts_t                sts,
  output logic                          result_valid,
  output tsrt_pkg::rsp_t                result
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned TW   = tsrt_pkg::TimeW;
  localparam int unsigned AW   = tsrt_pkg::AddrW;

  logic [AW-1:0] mem_tx [TABLE_ENTRIES];
  logic [AW-1:0] mem_rx [TABLE_ENTRIES];
  logic [TW-1:0] mem_b  [TABLE_ENTRIES];
  logic [TW-1:0] mem_l  [TABLE_ENTRIES];

  tsrt_pkg::req_t r;
  logic [CntW-1:0] count;
  logic [CntW-1:0] rd;      // read cursor
  logic [CntW-1:0] wr;      // compaction write cursor / shift cursor
  logic [TW:0]     idle;    // one spare bit for the saturation check
  logic [TW-1:0]   slot_s;
  logic            hit;
  tsrt_pkg::rsp_t  res;
  logic [1:0]      st_store; // store outcome, latched when the result is issued

  logic [IdxW-1:0] ri, wi, wim1;
  logic [AW-1:0]   e_tx, e_rx;
  logic [TW-1:0]   e_b, e_l;
  logic [TW:0]     e_end, stop_t, s_d;
  logic [TW+1:0]   idle_d;  // idle can already exceed the time range

  assign ri    = rd[IdxW-1:0];
  assign wi    = wr[IdxW-1:0];
  assign wim1  = wi - IdxW'(1);
  assign e_tx  = mem_tx[ri];
  assign e_rx  = mem_rx[ri];
  assign e_b   = mem_b[ri];
  assign e_l   = mem_l[ri];
  assign e_end = {1'b0, e_b} + {1'b0, e_l};
  assign idle_d = {1'b0, idle} + {2'b00, r.wanted_length};
  assign s_d    = {1'b0, slot_s} + {1'b0, r.wanted_length};
  assign stop_t = s_d;

  always_comb begin
    sts.scan_end   = (rd >= count);
    sts.op         = r.opcode;
    sts.past       = (r.wanted_start < r.current_time);
    sts.full       = (count >= CntW'(TABLE_ENTRIES));
    sts.conflict   = hit;
    sts.shift_done = (wr == '0) || (mem_b[wim1] <= slot_s);
    sts.stop       = 1'b0;
    if (r.opcode == tsrt_pkg::OP_RESERVE) begin
      sts.stop = (idle_d < {2'b00, e_b});
    end else if (r.opcode == tsrt_pkg::OP_POLL) begin
      sts.stop = ~sts.scan_end & ~r.device_busy & (e_tx == own_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish;
      if (cmd.exp_fin) count <= wr;
      if (cmd.write) count <= count + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r    <= req;
      rd   <= '0;
      wr   <= '0;
      idle <= {1'b0, req.wanted_start};
      hit  <= 1'b0;
      res  <= '0;
    end
    if (cmd.exp_step) begin
      rd <= rd + CntW'(1);
      if (!(e_end < {1'b0, r.current_time})) begin
        mem_tx[wi] <= e_tx;
        mem_rx[wi] <= e_rx;
        mem_b[wi]  <= e_b;
        mem_l[wi]  <= e_l;
        wr <= wr + CntW'(1);
      end
    end
    if (cmd.exp_fin) rd <= '0;
    if (cmd.srch_step) begin
      rd <= rd + CntW'(1);
      if (idle < e_end) idle <= e_end;
    end
    if (cmd.sat) begin
      if (r.opcode == tsrt_pkg::OP_ADD) begin
        slot_s <= r.wanted_start;
      end else if (idle[TW]) begin
        slot_s <= '1;
      end else begin
        slot_s <= idle[TW-1:0];
      end
    end
    if (cmd.scan_clr) rd <= '0;
    if (cmd.chk_step) begin
      rd <= rd + CntW'(1);
      if (({1'b0, e_b} < stop_t && stop_t < e_end) ||
          (e_b < slot_s && {1'b0, slot_s} < e_end)) hit <= 1'b1;
    end
    if (cmd.shift_init) wr <= count;
    if (cmd.shift_step) begin
      mem_tx[wi] <= mem_tx[wim1];
      mem_rx[wi] <= mem_rx[wim1];
      mem_b[wi]  <= mem_b[wim1];
      mem_l[wi]  <= mem_l[wim1];
      wr <= wr - CntW'(1);
    end
    if (cmd.write) begin
      mem_tx[wi] <= r.sender_address;
      mem_rx[wi] <= r.receiver_address;
      mem_b[wi]  <= slot_s;
      mem_l[wi]  <= r.wanted_length;
    end
    if (cmd.lkp_step) begin
      rd <= rd + CntW'(1);
      if (e_tx == r.sender_address && e_rx == r.receiver_address) hit <= 1'b1;
    end
    if (cmd.poll_step) rd <= rd + CntW'(1);
    if (cmd.finish) st_store <= cmd.write ? tsrt_pkg::ST_OK : tsrt_pkg::ST_FULL;
    if (cmd.poll_step && sts.stop) begin
      res.poll_action   <= (e_b <= r.current_time) ? tsrt_pkg::PA_START : tsrt_pkg::PA_WAIT;
      res.wait_delay    <= (e_b <= r.current_time) ? '0 : e_b - r.current_time;
      res.period_length <= e_l;
      res.period_peer   <= e_rx;
    end
  end

  always_comb begin
    result = '0;
    unique case (r.opcode)
      tsrt_pkg::OP_RESERVE: begin
        if (sts.past) begin
          result.status = tsrt_pkg::ST_PAST;
        end else begin
          result.granted_start = slot_s;
          result.status = hit ? tsrt_pkg::ST_CONFLICT : st_store;
        end
      end
      tsrt_pkg::OP_ADD: begin
        result.granted_start = slot_s;
        result.status = hit ? tsrt_pkg::ST_CONFLICT : st_store;
      end
      tsrt_pkg::OP_LOOKUP: result.pair_found = hit;
      default: result = res;
    endcase
  end

endmodule

// ===== sv/time_slot_reservation_table.sv =====
// ----------------------------------------------------------------------------
// time_slot_reservation_table
// sorted table of link reservations with reserve, lookup, poll and add
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low, and the result
// appears for one cycle with done high; the receiver cannot stall it. Each
// operation walks the table one entry per cycle through a single read port:
// an expiry pass, then a scan of the remaining entries (a gap search and an
// overlap check for a reserve), and for a store a shift of the later entries.
module time_slot_reservation_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  tsrt_pkg::req_t                 req,
  input  logic                           cfg_we,
  input  logic [tsrt_pkg::AddrW-1:0]     cfg_wdata,
  output logic                           done,
  output tsrt_pkg::rsp_t                 rsp
);

  logic [tsrt_pkg::AddrW-1:0] own_addr;
  tsrt_pkg::cmd_t cmd;
  tsrt_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_addr <= '0;
    end else if (cfg_we) begin
      own_addr <= cfg_wdata;
    end
  end

  tsrt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .sts  (sts)
  );

  tsrt_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .own_addr    (own_addr),
    .cmd         (cmd),
    .sts         (sts),
    .result_valid(done),
    .result      (rsp)
  );

endmodule
